// File: sv/bca_pkg.sv
// ----------------------------------------------------------------------------
// bca_pkg
// Shared constants, command and status types for the bitmap chunk allocator.
// ----------------------------------------------------------------------------
package bca_pkg;

   localparam int PAGE_COUNT      = 4;
   localparam int PAGE_BYTES      = 4096;
   localparam int CHUNK_BYTES     = 256;
   localparam int CHUNKS_PER_PAGE = PAGE_BYTES / CHUNK_BYTES;

   localparam int SIZE_W   = 13;
   localparam int PAGE_W   = 2;
   localparam int CHUNK_W  = 4;
   localparam int LEN_W    = 5;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 3;
   localparam int CHUNK_SHIFT = $clog2(CHUNK_BYTES);
   localparam int ADDR_W   = PAGE_W + CHUNK_W;
   localparam int ENTRIES  = PAGE_COUNT * CHUNKS_PER_PAGE;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_SIZE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic                load;
      logic                scan_clear;
      logic                scan_next;
      logic                open_page;
      logic                take;
      logic                release_run;
      logic                emit;
      logic [STATUS_W-1:0] emit_status;
   } bca_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_free;
      logic bad_size;
      logic page_open;
      logic page_fit;
      logic last_page;
      logic out_free;
   } bca_stat_type;

   // mask of len low ones, len up to a full page
   function automatic logic [CHUNKS_PER_PAGE-1:0] run_mask(input logic [LEN_W-1:0] len);
      logic [CHUNKS_PER_PAGE:0] t;
      t = ({{CHUNKS_PER_PAGE{1'b0}}, 1'b1} << len) - {{CHUNKS_PER_PAGE{1'b0}}, 1'b1};
      return t[CHUNKS_PER_PAGE-1:0];
   endfunction

endpackage

// File: sv/bca_dp.sv
// ----------------------------------------------------------------------------
// bca_dp
// Allocator datapath: free bitmap, run length store, page count, page
// first-fit search and the result register.
// ----------------------------------------------------------------------------
module bca_dp import bca_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  bca_cmd_type         cmd,
   output bca_stat_type        stat,
   input  logic                req_opcode,
   input  logic [SIZE_W-1:0]   req_size_bytes,
   input  logic [PAGE_W-1:0]   req_free_page,
   input  logic [CHUNK_W-1:0]  req_free_chunk,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [PAGE_W-1:0]   rsp_alloc_page,
   output logic [CHUNK_W-1:0]  rsp_alloc_chunk,
   output logic [LEN_W-1:0]    rsp_freed_chunks
);

   logic                       opcode_ff;
   logic [SIZE_W-1:0]          size_ff;
   logic [PAGE_W-1:0]          fpage_ff;
   logic [CHUNK_W-1:0]         fchunk_ff;
   logic [PAGE_W-1:0]          scan_page_ff;
   logic [COUNT_W-1:0]         pages_ff;
   logic [CHUNKS_PER_PAGE-1:0] free_map_ff [PAGE_COUNT];
   logic [ENTRIES-1:0]         len_valid_ff;
   logic [LEN_W-1:0]           len_mem [ENTRIES];
   logic [LEN_W-1:0]           rd_len_ff;
   logic                       rd_valid_ff;
   logic                       rsp_valid_ff;
   logic [STATUS_W-1:0]        status_ff;
   logic [PAGE_W-1:0]          apage_ff;
   logic [CHUNK_W-1:0]         achunk_ff;
   logic [LEN_W-1:0]           freed_ff;

   logic [LEN_W-1:0]           req_len;
   logic [CHUNKS_PER_PAGE-1:0] req_mask;
   logic [CHUNKS_PER_PAGE-1:0] page_map;
   logic                       fit_found;
   logic [CHUNK_W-1:0]         fit_start;
   logic [LEN_W-1:0]           old_len;
   logic [ADDR_W-1:0]          wr_addr;
   logic [ADDR_W-1:0]          rd_addr;

   assign req_len  = LEN_W'(size_ff >> CHUNK_SHIFT);
   assign req_mask = run_mask(req_len);
   assign page_map = free_map_ff[scan_page_ff];
   assign old_len  = rd_valid_ff ? rd_len_ff : '0;
   assign wr_addr  = {scan_page_ff, fit_start};
   assign rd_addr  = {fpage_ff, fchunk_ff};

   // first fit over all start positions of the current page
   always_comb begin
      fit_found = 1'b0;
      fit_start = '0;
      for (int s = CHUNKS_PER_PAGE - 1; s >= 0; s--) begin
         if (({1'b0, req_len} + 6'(s) <= 6'(CHUNKS_PER_PAGE)) &&
             (((page_map >> s) & req_mask) == req_mask)) begin
            fit_found = 1'b1;
            fit_start = CHUNK_W'(s);
         end
      end
   end

   assign stat.is_free   = (opcode_ff == OP_FREE);
   assign stat.bad_size  = (size_ff == '0) || (size_ff[CHUNK_SHIFT-1:0] != '0);
   assign stat.page_open = ({1'b0, scan_page_ff} < pages_ff);
   assign stat.page_fit  = fit_found;
   assign stat.last_page = (scan_page_ff == PAGE_W'(PAGE_COUNT - 1));
   assign stat.out_free  = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         opcode_ff <= req_opcode;
         size_ff   <= req_size_bytes;
         fpage_ff  <= req_free_page;
         fchunk_ff <= req_free_chunk;
      end
      if (cmd.take) begin
         len_mem[wr_addr] <= req_len;
      end
      rd_len_ff <= len_mem[rd_addr];
      if (cmd.emit) begin
         status_ff <= cmd.emit_status;
         apage_ff  <= cmd.take ? scan_page_ff : '0;
         achunk_ff <= cmd.take ? fit_start : '0;
         freed_ff  <= cmd.release_run ? old_len : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_page_ff <= '0;
         pages_ff     <= '0;
         len_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int p = 0; p < PAGE_COUNT; p++) begin
            free_map_ff[p] <= '1;
         end
      end else begin
         rd_valid_ff <= len_valid_ff[rd_addr];
         if (cmd.scan_clear) begin
            scan_page_ff <= '0;
         end else if (cmd.scan_next) begin
            scan_page_ff <= scan_page_ff + PAGE_W'(1);
         end
         if (cmd.open_page) begin
            pages_ff <= pages_ff + COUNT_W'(1);
         end
         if (cmd.take) begin
            free_map_ff[scan_page_ff] <= page_map & ~(req_mask << fit_start);
            len_valid_ff[wr_addr]     <= 1'b1;
         end
         if (cmd.release_run) begin
            free_map_ff[fpage_ff] <= free_map_ff[fpage_ff] | (run_mask(old_len) << fchunk_ff);
            len_valid_ff[rd_addr] <= 1'b0;
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_alloc_page   = apage_ff;
   assign rsp_alloc_chunk  = achunk_ff;
   assign rsp_freed_chunks = freed_ff;

`ifndef ASSERT_OFF
   a_take_fits: assert property (@(posedge clock) disable iff (reset)
      cmd.take |-> fit_found && !stat.bad_size && !stat.is_free)
      else $error("run taken without a fit");
   a_emit_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten before taken");
   a_pages_bound: assert property (@(posedge clock) disable iff (reset)
      pages_ff <= COUNT_W'(PAGE_COUNT))
      else $error("page count past limit");
   a_open_room: assert property (@(posedge clock) disable iff (reset)
      cmd.open_page |-> pages_ff < COUNT_W'(PAGE_COUNT) && !stat.page_open)
      else $error("page opened with none left");
`endif

endmodule

// File: sv/bca_ctrl.sv
// ----------------------------------------------------------------------------
// bca_ctrl
// Allocator controller: sequences decode, page scan and free for one item.
// ----------------------------------------------------------------------------
module bca_ctrl import bca_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  bca_stat_type stat,
   output bca_cmd_type  cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_DISPATCH,
      S_SCAN,
      S_FREE_WB
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (stat.is_free) begin
               state_in = S_FREE_WB;
            end else if (stat.bad_size) begin
               if (stat.out_free) begin
                  cmd.emit        = 1'b1;
                  cmd.emit_status = ST_BAD_SIZE;
                  state_in        = S_IDLE;
               end
            end else begin
               cmd.scan_clear = 1'b1;
               state_in       = S_SCAN;
            end
         end
         S_SCAN: begin
            if (stat.out_free) begin
               if (stat.page_open) begin
                  if (stat.page_fit) begin
                     cmd.take        = 1'b1;
                     cmd.emit        = 1'b1;
                     cmd.emit_status = ST_OK;
                     state_in        = S_IDLE;
                  end else if (stat.last_page) begin
                     cmd.emit        = 1'b1;
                     cmd.emit_status = ST_NO_SPACE;
                     state_in        = S_IDLE;
                  end else begin
                     cmd.scan_next = 1'b1;
                  end
               end else begin
                  cmd.open_page   = 1'b1;
                  cmd.take        = stat.page_fit;
                  cmd.emit        = 1'b1;
                  cmd.emit_status = stat.page_fit ? ST_OK : ST_NO_SPACE;
                  state_in        = S_IDLE;
               end
            end
         end
         S_FREE_WB: begin
            if (stat.out_free) begin
               cmd.release_run = 1'b1;
               cmd.emit        = 1'b1;
               cmd.emit_status = ST_OK;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef ASSERT_OFF
   a_one_action: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.scan_clear, cmd.scan_next, cmd.release_run, cmd.take && !cmd.emit}))
      else $error("conflicting datapath commands");
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == S_DISPATCH)
      else $error("load without dispatch");
   a_emit_ends: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> state_ff == S_IDLE)
      else $error("result given while item still busy");
`endif

endmodule

// File: sv/bitmap_chunk_allocator_top.sv
// ----------------------------------------------------------------------------
// bitmap_chunk_allocator_top
// First-fit bitmap chunk allocator over a fixed set of pages.
//
//   channel  dir  handshake            payload
//   req      in   req_valid/req_ready  opcode, size_bytes, free_page, free_chunk
//   rsp      out  rsp_valid/rsp_ready  status, alloc_page, alloc_chunk,
//                                      freed_chunks
//
// allocate: after the decode step, one page searched per cycle by the
//   first-fit window check while no result waits
// free: result after the registered run length read; bad size: result at decode
// one item at a time; the next item is taken while a result waits
// a waiting result stalls the page scan and the final step of the next item
// synchronous reset marks all chunks free and clears the page count and run valid bits at once
// ----------------------------------------------------------------------------
module bitmap_chunk_allocator_top import bca_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_opcode,
   input  logic [SIZE_W-1:0]   req_size_bytes,
   input  logic [PAGE_W-1:0]   req_free_page,
   input  logic [CHUNK_W-1:0]  req_free_chunk,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [PAGE_W-1:0]   rsp_alloc_page,
   output logic [CHUNK_W-1:0]  rsp_alloc_chunk,
   output logic [LEN_W-1:0]    rsp_freed_chunks
);

   bca_cmd_type  cmd;
   bca_stat_type stat;

   bca_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   bca_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_opcode       (req_opcode),
      .req_size_bytes   (req_size_bytes),
      .req_free_page    (req_free_page),
      .req_free_chunk   (req_free_chunk),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_alloc_page   (rsp_alloc_page),
      .rsp_alloc_chunk  (rsp_alloc_chunk),
      .rsp_freed_chunks (rsp_freed_chunks)
   );

endmodule
